[rtl/mpm_pkg.sv]
// ----------------------------------------------------------------------------
// mpm_pkg
// Sizes, codes and types shared by the multi-pattern matcher.
// ----------------------------------------------------------------------------
package mpm_pkg;

  localparam int NODES      = 4096;
  localparam int PATTERNS   = 1024;
  localparam int ALPHABET   = 256;
  localparam int COUNT_BITS = 32;

  localparam int NODE_W     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int NCNT_W     = $clog2(NODES + 1);
  localparam int PAT_W      = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int MARK_W     = $clog2(PATTERNS + 1);
  localparam int SYM_W      = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int GOTO_DEPTH = NODES * ALPHABET;
  localparam int GOTO_AW    = $clog2(GOTO_DEPTH);

  typedef enum logic [2:0] {
    OP_PAT_BYTE = 3'd0,
    OP_PAT_END  = 3'd1,
    OP_BUILD    = 3'd2,
    OP_TEXT     = 3'd3,
    OP_READ     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NODE_FULL = 2'd1,
    ST_PAT_FULL  = 2'd2
  } status_e;

  // who issued the current child lookup
  typedef enum logic [1:0] {
    C_INS  = 2'd0,
    C_BCH  = 2'd1,
    C_BFL  = 2'd2,
    C_SCAN = 2'd3
  } ctx_e;

  // parent and edge symbol of a node, used to validate goto entries
  typedef struct packed {
    logic [NODE_W-1:0] parent;
    logic [SYM_W-1:0]  sym;
  } info_t;

  localparam int INFO_W = $bits(info_t);

endpackage

[rtl/mpm_ram.sv]
// ----------------------------------------------------------------------------
// mpm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/multi_pattern_matcher.sv]
// ----------------------------------------------------------------------------
// multi_pattern_matcher
// Aho-Corasick engine: trie build, failure links, text scan, match counts.
// ----------------------------------------------------------------------------
// One transfer in, one result out, one item at a time. After reset the count
// memory is cleared, all PATTERNS (1024) entries, before the first input is
// taken. Each trie lookup steps through a goto read, a parent check read and
// a decide. Pattern end and out-of-range items are answered from idle, a
// count read after one count memory read. A text byte takes a lookup and a
// failure hop per miss, then walks the output chain and bumps the count of
// each marked node. A build looks up every symbol of each trie node, plus
// the failure searches. Goto entries are trusted only when the node they
// name records that parent and symbol, so the goto memory needs no clearing.
module multi_pattern_matcher
  import mpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic [9:0]  pattern_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [9:0]  assigned_id_o,
  output logic [7:0]  matches_here_o,
  output logic [31:0] match_count_o
);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_LK0   = 13'b0000000000100,
    S_LK1   = 13'b0000000001000,
    S_LK2   = 13'b0000000010000,
    S_FR    = 13'b0000000100000,
    S_FD    = 13'b0000001000000,
    S_BPOP  = 13'b0000010000000,
    S_BCUR  = 13'b0000100000000,
    S_WRD   = 13'b0001000000000,
    S_WDATA = 13'b0010000000000,
    S_WINC  = 13'b0100000000000,
    S_RDCNT = 13'b1000000000000
  } state_e;

  state_e            state_q, state_d;
  ctx_e              ctx_q, ctx_d;
  logic [2:0]        op_q, op_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic [9:0]        assigned_q, assigned_d;
  logic [7:0]        hits_q, hits_d;
  logic [31:0]       count_q, count_d;
  logic [NCNT_W-1:0] nodes_used_q, nodes_used_d;
  logic [MARK_W-1:0] pats_used_q, pats_used_d;
  logic [NODE_W-1:0] insert_q, insert_d;
  logic [NODE_W-1:0] match_q, match_d;
  logic [NODE_W-1:0] lk_node_q, lk_node_d;
  logic [SYM_W-1:0]  lk_sym_q, lk_sym_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic [NODE_W-1:0] cur_q, cur_d;
  logic [NODE_W-1:0] c_q, c_d;
  logic [NODE_W-1:0] g_q, g_d;
  logic [NCNT_W-1:0] head_q, head_d;
  logic [NCNT_W-1:0] tail_q, tail_d;
  logic [PAT_W-1:0]  id_q, id_d;
  logic [PAT_W-1:0]  clr_q, clr_d;

  logic                  goto_we;
  logic [GOTO_AW-1:0]    goto_addr;
  logic [NODE_W-1:0]     goto_rdata;
  logic                  info_we;
  info_t                 info_rdata;
  logic                  fail_we;
  logic [NODE_W-1:0]     fail_waddr, fail_wdata, fail_rdata;
  logic                  mark_we;
  logic [NODE_W-1:0]     mark_waddr;
  logic [MARK_W-1:0]     mark_wdata, mark_rdata;
  logic                  q_we;
  logic [NODE_W-1:0]     q_waddr, q_wdata, q_rdata;
  logic                  cnt_we;
  logic [PAT_W-1:0]      cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic [63:0]           cnt_ext;

  logic              child_ok;
  logic [NODE_W-1:0] child;
  logic [NODE_W-1:0] new_node;
  logic              do_enq, do_next;
  logic [NODE_W-1:0] enq_node;
  logic              in_xfer;

  assign new_node  = nodes_used_q[NODE_W-1:0];
  assign goto_addr = GOTO_AW'(lk_node_q) * GOTO_AW'(ALPHABET) + GOTO_AW'(lk_sym_q);
  assign child_ok  = (g_q != '0) && (NCNT_W'(g_q) < nodes_used_q)
                     && (info_rdata.parent == lk_node_q) && (info_rdata.sym == lk_sym_q);
  assign child     = child_ok ? g_q : '0;
  assign cnt_ext   = 64'(cnt_rdata);
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    ctx_d        = ctx_q;
    op_d         = op_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    assigned_d   = assigned_q;
    hits_d       = hits_q;
    count_d      = count_q;
    nodes_used_d = nodes_used_q;
    pats_used_d  = pats_used_q;
    insert_d     = insert_q;
    match_d      = match_q;
    lk_node_d    = lk_node_q;
    lk_sym_d     = lk_sym_q;
    sym_d        = sym_q;
    cur_d        = cur_q;
    c_d          = c_q;
    g_d          = g_q;
    head_d       = head_q;
    tail_d       = tail_q;
    id_d         = id_q;
    clr_d        = clr_q;
    goto_we      = 1'b0;
    info_we      = 1'b0;
    fail_we      = 1'b0;
    fail_waddr   = new_node;
    fail_wdata   = '0;
    mark_we      = 1'b0;
    mark_waddr   = new_node;
    mark_wdata   = '0;
    q_we         = 1'b0;
    q_waddr      = tail_q[NODE_W-1:0];
    q_wdata      = '0;
    cnt_we       = 1'b0;
    cnt_waddr    = id_q;
    cnt_wdata    = '0;
    cnt_raddr    = id_q;
    do_enq       = 1'b0;
    do_next      = 1'b0;
    enq_node     = c_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        clr_d     = clr_q + PAT_W'(1);
        if (clr_q == PAT_W'(PATTERNS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          op_d       = operation_i;
          status_d   = ST_OK;
          assigned_d = '0;
          hits_d     = '0;
          count_d    = '0;
          case (operation_i)
            OP_PAT_BYTE: begin
              if (32'(data_byte_i) >= ALPHABET) begin
                out_valid_d = 1'b1;
              end else begin
                lk_node_d = insert_q;
                lk_sym_d  = SYM_W'(data_byte_i);
                ctx_d     = C_INS;
                state_d   = S_LK0;
              end
            end
            OP_PAT_END: begin
              if (32'(pats_used_q) >= PATTERNS) begin
                status_d = ST_PAT_FULL;
              end else begin
                mark_we     = 1'b1;
                mark_waddr  = insert_q;
                mark_wdata  = pats_used_q + MARK_W'(1);
                assigned_d  = 10'(pats_used_q);
                pats_used_d = pats_used_q + MARK_W'(1);
              end
              insert_d    = '0;
              out_valid_d = 1'b1;
            end
            OP_BUILD: begin
              q_we    = 1'b1;
              q_waddr = '0;
              head_d  = '0;
              tail_d  = NCNT_W'(1);
              state_d = S_BPOP;
            end
            OP_TEXT: begin
              if (32'(data_byte_i) >= ALPHABET) begin
                match_d     = '0;
                out_valid_d = 1'b1;
              end else begin
                lk_node_d = match_q;
                lk_sym_d  = SYM_W'(data_byte_i);
                ctx_d     = C_SCAN;
                state_d   = S_LK0;
              end
            end
            OP_READ: begin
              if (32'(pattern_index_i) < PATTERNS) begin
                cnt_raddr = PAT_W'(pattern_index_i);
                state_d   = S_RDCNT;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_LK0: begin
        state_d = S_LK1;
      end
      S_LK1: begin
        g_d     = goto_rdata;
        state_d = S_LK2;
      end
      S_LK2: begin
        case (ctx_q)
          C_INS: begin
            state_d     = S_IDLE;
            out_valid_d = 1'b1;
            if (child != '0) begin
              insert_d = child;
            end else if (32'(nodes_used_q) >= NODES) begin
              status_d = ST_NODE_FULL;
            end else begin
              goto_we      = 1'b1;
              info_we      = 1'b1;
              fail_we      = 1'b1;
              mark_we      = 1'b1;
              nodes_used_d = nodes_used_q + NCNT_W'(1);
              insert_d     = new_node;
            end
          end
          C_BCH: begin
            if (child == '0) begin
              do_next = 1'b1;
            end else if (lk_node_q == '0) begin
              fail_we    = 1'b1;
              fail_waddr = child;
              do_enq     = 1'b1;
              enq_node   = child;
              do_next    = 1'b1;
            end else begin
              c_d     = child;
              state_d = S_FR;
            end
          end
          C_BFL: begin
            if (child != '0 || lk_node_q == '0) begin
              fail_we    = 1'b1;
              fail_waddr = c_q;
              fail_wdata = child;
              do_enq     = 1'b1;
              do_next    = 1'b1;
            end else begin
              state_d = S_FR;
            end
          end
          default: begin
            if (child != '0 || lk_node_q == '0) begin
              match_d   = child;
              lk_node_d = child;
              state_d   = S_WRD;
            end else begin
              state_d = S_FR;
            end
          end
        endcase
        if (do_enq && 32'(tail_q) < NODES) begin
          q_we    = 1'b1;
          q_wdata = enq_node;
          tail_d  = tail_q + NCNT_W'(1);
        end
        if (do_next) begin
          if (sym_q == SYM_W'(ALPHABET - 1)) begin
            state_d = S_BPOP;
          end else begin
            sym_d     = sym_q + SYM_W'(1);
            lk_node_d = cur_q;
            lk_sym_d  = sym_q + SYM_W'(1);
            ctx_d     = C_BCH;
            state_d   = S_LK0;
          end
        end
      end
      S_FR: begin
        state_d = S_FD;
      end
      S_FD: begin
        lk_node_d = fail_rdata;
        ctx_d     = (ctx_q == C_SCAN) ? C_SCAN : C_BFL;
        state_d   = S_LK0;
      end
      S_BPOP: begin
        if (head_q < tail_q && 32'(head_q) < NODES) begin
          head_d  = head_q + NCNT_W'(1);
          state_d = S_BCUR;
        end else begin
          match_d     = '0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_BCUR: begin
        cur_d     = q_rdata;
        lk_node_d = q_rdata;
        sym_d     = '0;
        lk_sym_d  = '0;
        ctx_d     = C_BCH;
        state_d   = S_LK0;
      end
      S_WRD: begin
        if (lk_node_q == '0) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          state_d = S_WDATA;
        end
      end
      S_WDATA: begin
        lk_node_d = fail_rdata;
        if (mark_rdata != '0) begin
          id_d      = PAT_W'(mark_rdata - MARK_W'(1));
          cnt_raddr = PAT_W'(mark_rdata - MARK_W'(1));
          if (hits_q != 8'hFF) begin
            hits_d = hits_q + 8'd1;
          end
          state_d = S_WINC;
        end else begin
          state_d = S_WRD;
        end
      end
      S_WINC: begin
        if (cnt_rdata != '1) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rdata + COUNT_BITS'(1);
        end
        state_d = S_WRD;
      end
      S_RDCNT: begin
        count_d     = (cnt_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cnt_ext[31:0];
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      ctx_q        <= C_INS;
      op_q         <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= '0;
      assigned_q   <= '0;
      hits_q       <= '0;
      count_q      <= '0;
      nodes_used_q <= NCNT_W'(1);
      pats_used_q  <= '0;
      insert_q     <= '0;
      match_q      <= '0;
      lk_node_q    <= '0;
      lk_sym_q     <= '0;
      sym_q        <= '0;
      cur_q        <= '0;
      c_q          <= '0;
      g_q          <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      id_q         <= '0;
      clr_q        <= '0;
    end else begin
      state_q      <= state_d;
      ctx_q        <= ctx_d;
      op_q         <= op_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      assigned_q   <= assigned_d;
      hits_q       <= hits_d;
      count_q      <= count_d;
      nodes_used_q <= nodes_used_d;
      pats_used_q  <= pats_used_d;
      insert_q     <= insert_d;
      match_q      <= match_d;
      lk_node_q    <= lk_node_d;
      lk_sym_q     <= lk_sym_d;
      sym_q        <= sym_d;
      cur_q        <= cur_d;
      c_q          <= c_d;
      g_q          <= g_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      id_q         <= id_d;
      clr_q        <= clr_d;
    end
  end

  mpm_ram #(.WIDTH(NODE_W), .DEPTH(GOTO_DEPTH)) u_goto (
    .clk_i   (clk_i),
    .we_i    (goto_we),
    .waddr_i (goto_addr),
    .wdata_i (new_node),
    .raddr_i (goto_addr),
    .rdata_o (goto_rdata)
  );

  mpm_ram #(.WIDTH(INFO_W), .DEPTH(NODES)) u_info (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (new_node),
    .wdata_i ({lk_node_q, lk_sym_q}),
    .raddr_i (goto_rdata),
    .rdata_o (info_rdata)
  );

  mpm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_fail (
    .clk_i   (clk_i),
    .we_i    (fail_we),
    .waddr_i (fail_waddr),
    .wdata_i (fail_wdata),
    .raddr_i (lk_node_q),
    .rdata_o (fail_rdata)
  );

  mpm_ram #(.WIDTH(MARK_W), .DEPTH(NODES)) u_mark (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (lk_node_q),
    .rdata_o (mark_rdata)
  );

  mpm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (head_q[NODE_W-1:0]),
    .rdata_o (q_rdata)
  );

  mpm_ram #(.WIDTH(COUNT_BITS), .DEPTH(PATTERNS)) u_count (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign assigned_id_o  = assigned_q;
  assign matches_here_o = hits_q;
  assign match_count_o  = count_q;

  a_nodes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nodes_used_q != '0) && (32'(nodes_used_q) <= NODES))
    else $error("node count out of range");

  a_pats_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pats_used_q) <= PATTERNS)
    else $error("pattern count out of range");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) != S_CLEAR)
    else $error("result produced during count clearing");

  a_hits_text_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && hits_q != '0) |-> op_q == OP_TEXT)
    else $error("matches reported for a non-text item");

  a_node_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_NODE_FULL) |-> 32'(nodes_used_q) == NODES)
    else $error("node store full reported early");

endmodule

[tb/multi_pattern_matcher_tb.sv]
// ----------------------------------------------------------------------------
// multi_pattern_matcher_tb
// Self-checking bench for the Aho-Corasick matcher. It inserts patterns,
// builds the failure links and scans text. It reads counts back and checks
// every result against a predictor under four idle modes of the ports.
// ----------------------------------------------------------------------------
module multi_pattern_matcher_tb;
  import mpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  st;
    logic [9:0]  id;
    logic [7:0]  hits;
    logic [31:0] cnt;
  } answer_t;

  class match_scoreboard;
    answer_t     awaited[$];
    int          errors;
    int          checked;
    int          text_hits;
    int unsigned child[int];
    int unsigned fail[NODES];
    int unsigned mark[NODES];
    logic [31:0] count[PATTERNS];
    int unsigned nodes_used;
    int unsigned pats_used;
    int unsigned ins_node;
    int unsigned scan_node;

    function new();
      foreach (fail[i]) begin
        fail[i] = 0;
        mark[i] = 0;
      end
      foreach (count[i]) count[i] = '0;
      nodes_used = 1;
    endfunction

    function int unsigned kid(int unsigned n, int unsigned s);
      return child.exists(n * ALPHABET + s) ? child[n * ALPHABET + s] : 0;
    endfunction

    function void build_links();
      int unsigned q[$];
      int unsigned n, c, f, p;
      q.push_back(0);
      while (q.size() != 0) begin
        n = q.pop_front();
        for (int s = 0; s < ALPHABET; s++) begin
          c = kid(n, s);
          if (c == 0) continue;
          f = 0;
          if (n != 0) begin
            p = fail[n];
            forever begin
              if (kid(p, s) != 0) begin
                f = kid(p, s);
                break;
              end
              if (p == 0) break;
              p = fail[p];
            end
          end
          fail[c] = f;
          q.push_back(c);
        end
      end
      scan_node = 0;
    endfunction

    function logic [7:0] scan(int unsigned s);
      int unsigned p;
      logic [7:0]  hits;
      p = scan_node;
      hits = '0;
      while (p != 0 && kid(p, s) == 0) p = fail[p];
      p = kid(p, s);
      scan_node = p;
      while (p != 0) begin
        if (mark[p] != 0) begin
          if (count[mark[p] - 1] != 32'hffff_ffff) count[mark[p] - 1]++;
          if (hits != 8'hff) hits++;
        end
        p = fail[p];
      end
      return hits;
    endfunction

    function void note_input(logic [2:0] op, logic [7:0] b, logic [9:0] idx);
      answer_t a;
      int unsigned c;
      a = '{ST_OK, '0, '0, '0};
      case (op)
        OP_PAT_BYTE: begin
          c = kid(ins_node, b);
          if (c == 0 && nodes_used >= NODES) begin
            a.st = ST_NODE_FULL;
          end else begin
            if (c == 0) begin
              c = nodes_used++;
              child[ins_node * ALPHABET + b] = c;
              fail[c] = 0;
              mark[c] = 0;
            end
            ins_node = c;
          end
        end
        OP_PAT_END: begin
          if (pats_used >= PATTERNS) begin
            a.st = ST_PAT_FULL;
          end else begin
            mark[ins_node] = pats_used + 1;
            a.id = pats_used;
            pats_used++;
          end
          ins_node = 0;
        end
        OP_BUILD: build_links();
        OP_TEXT: begin
          a.hits = scan(b);
          if (a.hits != 0) text_hits++;
        end
        OP_READ: a.cnt = count[idx];
        default: ;
      endcase
      awaited.push_back(a);
    endfunction

    function void check_result(logic [1:0] st, logic [9:0] id, logic [7:0] hits,
                               logic [31:0] cnt);
      answer_t a;
      checked++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result st=%0d id=%0d hits=%0d cnt=%0d",
                 $time, st, id, hits, cnt);
        errors++;
        return;
      end
      a = awaited.pop_front();
      if (st !== a.st) begin
        $display("%0t: status exp %0d got %0d", $time, a.st, st);
        errors++;
      end
      if (id !== a.id) begin
        $display("%0t: assigned_id exp %0d got %0d", $time, a.id, id);
        errors++;
      end
      if (hits !== a.hits) begin
        $display("%0t: matches_here exp %0d got %0d", $time, a.hits, hits);
        errors++;
      end
      if (cnt !== a.cnt) begin
        $display("%0t: match_count exp %0d got %0d", $time, a.cnt, cnt);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  operation_i;
  logic [7:0]  data_byte_i;
  logic [9:0]  pattern_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [9:0]  assigned_id_o;
  logic [7:0]  matches_here_o;
  logic [31:0] match_count_o;

  match_scoreboard sb = new();
  int idle_mode;
  int sent;

  multi_pattern_matcher dut (.*);

  always #5 clk_i = ~clk_i;

  // idle_mode: 0 none, 1 sender 75%, 2 receiver 75%, 3 both 16%
  always @(posedge clk_i) begin
    case (idle_mode)
      2: out_ready_i <= ($urandom_range(99) >= 75);
      3: out_ready_i <= ($urandom_range(99) >= 16);
      default: out_ready_i <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_input(operation_i, data_byte_i, pattern_index_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(status_o, assigned_id_o, matches_here_o, match_count_o);
    end
  end

  task automatic send(logic [2:0] op, logic [7:0] b = '0, logic [9:0] idx = '0);
    int pct;
    pct = (idle_mode == 1) ? 75 : (idle_mode == 3) ? 16 : 0;
    if ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    data_byte_i     <= b;
    pattern_index_i <= idx;
    @(posedge clk_i iff in_ready_o);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i iff sb.awaited.size() == 0);
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'h61 + 8'($urandom_range(2));
  endfunction

  initial begin
    #200ms;
    $display("** multi_pattern_matcher: FAILED **");
    $finish;
  end

  initial begin
    int k;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    operation_i     <= '0;
    data_byte_i     <= '0;
    pattern_index_i <= '0;
    idle_mode = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: overlapping patterns, extreme bytes, empty pattern
    send(OP_PAT_END);
    send(OP_PAT_BYTE, "h"); send(OP_PAT_BYTE, "e");
    send(OP_PAT_END);
    send(OP_PAT_BYTE, "s"); send(OP_PAT_BYTE, "h"); send(OP_PAT_BYTE, "e");
    send(OP_PAT_END);
    send(OP_PAT_BYTE, 8'h00); send(OP_PAT_BYTE, 8'hff); send(OP_PAT_END);
    send(OP_PAT_BYTE, "e"); send(OP_PAT_END);
    send(OP_BUILD);
    send(OP_TEXT, "s"); send(OP_TEXT, "h"); send(OP_TEXT, "e");
    send(OP_TEXT, 8'h00); send(OP_TEXT, 8'hff); send(OP_TEXT, "e");
    send(OP_READ, '0, 10'd2); send(OP_READ, '0, 10'd1023); send(OP_READ, '0, 10'd4);
    send(3'd5, 8'hff, 10'h3ff); send(3'd6); send(3'd7, 8'haa, 10'h155);

    for (int round = 0; round < 8; round++) begin
      idle_mode = round % 4;
      repeat (3) begin
        repeat ($urandom_range(4, 1)) send(OP_PAT_BYTE, pick_byte());
        send(OP_PAT_END);
      end
      send(OP_BUILD);
      repeat (60) begin
        k = $urandom_range(99);
        if (k < 75) send(OP_TEXT, pick_byte());
        else if (k < 90) send(OP_READ, '0, 10'($urandom_range(sb.pats_used)));
        else if (k < 94) send(OP_READ, '0, 10'($urandom_range(1023)));
        else if (k < 96) send(OP_PAT_BYTE, pick_byte());
        else if (k < 97) send(OP_PAT_END);
        else if (k < 98) send(OP_BUILD);
        else send(3'($urandom_range(7, 5)), 8'($urandom), 10'($urandom));
      end
      if (round == 2) drain();
    end

    idle_mode = 3;
    repeat (20) send(OP_TEXT, pick_byte());
    repeat (10) send(OP_READ, '0, 10'($urandom));

    drain();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d items, checked %0d results, %0d text bytes with matches.",
             sent, sb.checked, sb.text_hits);
    $display("Covered all operations, rebuilt links between scans, four idle modes.");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("** multi_pattern_matcher: PASSED **");
    end else begin
      $display("** multi_pattern_matcher: FAILED **");
    end
    $finish;
  end

endmodule
